// ===== sv/stodc_pkg.sv =====
// shared types, command codes and divide-by-constant helpers for the time-of-day counter
package stodc_pkg;

   localparam logic [2:0] CMD_RESET = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_ADD   = 3'd4;

   localparam logic [1:0] CSR_TIME_SCALE   = 2'd0;
   localparam logic [1:0] CSR_START_DAY    = 2'd1;
   localparam logic [1:0] CSR_START_HOUR   = 2'd2;
   localparam logic [1:0] CSR_START_MINUTE = 2'd3;

   // stages in the amount splitter: input, then multiply and correct for 60, 60, 24
   localparam int SPLIT_STAGES = 7;

   // floor(2^32 / divisor), the estimate lands on the quotient or one below it
   localparam logic [31:0] RECIP_60 = 32'd71582788;
   localparam logic [31:0] RECIP_24 = 32'd178956970;

   localparam logic [5:0] SCALE_MAX = 6'd60;
   localparam logic [5:0] SEC_HOLD  = 6'd59;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        paused;
      logic [5:0]  rtc_seconds;
      logic [31:0] add_amount;
   } req_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        paused;
      logic [5:0]  rtc_seconds;
      logic [31:0] num;
      logic [26:0] est;
      logic [5:0]  sec_part;
      logic [5:0]  min_part;
      logic [4:0]  hour_part;
      logic [15:0] day_part;
   } split_type;

   typedef struct packed {
      logic [26:0] quot;
      logic [6:0]  rem;
   } qr_type;

   function automatic logic [26:0] recip_est(input logic [31:0] num, input logic [31:0] recip);
      logic [63:0] prod;
      prod = {32'd0, num} * {32'd0, recip};
      return prod[58:32];
   endfunction

   function automatic qr_type fix60(input logic [31:0] num, input logic [26:0] est);
      logic [32:0] back;
      logic [32:0] diff;
      qr_type      res;
      back = ({6'd0, est} << 6) - ({6'd0, est} << 2);
      diff = {1'b0, num} - back;
      // remainder is below 120 here
      if (diff[6:0] >= 7'd60) begin
         res.quot = est + 27'd1;
         res.rem  = diff[6:0] - 7'd60;
      end else begin
         res.quot = est;
         res.rem  = diff[6:0];
      end
      return res;
   endfunction

   function automatic qr_type fix24(input logic [31:0] num, input logic [26:0] est);
      logic [32:0] back;
      logic [32:0] diff;
      qr_type      res;
      back = ({6'd0, est} << 4) + ({6'd0, est} << 3);
      diff = {1'b0, num} - back;
      if (diff[6:0] >= 7'd24) begin
         res.quot = est + 27'd1;
         res.rem  = diff[6:0] - 7'd24;
      end else begin
         res.quot = est;
         res.rem  = diff[6:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/stodc_split.sv =====
// pipeline that splits the add amount into days, hours, minutes and seconds
module stodc_split (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  stodc_pkg::req_type   in_req,
   output logic                 out_valid,
   input  logic                 out_stall,
   output stodc_pkg::split_type out_item
);

   logic [stodc_pkg::SPLIT_STAGES-1:0] valid_ff;
   logic [stodc_pkg::SPLIT_STAGES-1:0] adv;
   stodc_pkg::split_type stage_ff [stodc_pkg::SPLIT_STAGES];
   stodc_pkg::split_type stage_in [stodc_pkg::SPLIT_STAGES];
   stodc_pkg::qr_type    qr_sec;
   stodc_pkg::qr_type    qr_min;
   stodc_pkg::qr_type    qr_hour;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[stodc_pkg::SPLIT_STAGES-1] = !valid_ff[stodc_pkg::SPLIT_STAGES-1] || !out_stall;
      for (int i = stodc_pkg::SPLIT_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[stodc_pkg::SPLIT_STAGES-1];
   assign out_item  = stage_ff[stodc_pkg::SPLIT_STAGES-1];

   always_comb begin
      stage_in[0]             = '0;
      stage_in[0].cmd         = in_req.cmd;
      stage_in[0].paused      = in_req.paused;
      stage_in[0].rtc_seconds = in_req.rtc_seconds;
      stage_in[0].num         = in_req.add_amount;

      stage_in[1]     = stage_ff[0];
      stage_in[1].est = stodc_pkg::recip_est(stage_ff[0].num, stodc_pkg::RECIP_60);

      qr_sec               = stodc_pkg::fix60(stage_ff[1].num, stage_ff[1].est);
      stage_in[2]          = stage_ff[1];
      stage_in[2].num      = {5'd0, qr_sec.quot};
      stage_in[2].sec_part = qr_sec.rem[5:0];

      stage_in[3]     = stage_ff[2];
      stage_in[3].est = stodc_pkg::recip_est(stage_ff[2].num, stodc_pkg::RECIP_60);

      qr_min               = stodc_pkg::fix60(stage_ff[3].num, stage_ff[3].est);
      stage_in[4]          = stage_ff[3];
      stage_in[4].num      = {5'd0, qr_min.quot};
      stage_in[4].min_part = qr_min.rem[5:0];

      stage_in[5]     = stage_ff[4];
      stage_in[5].est = stodc_pkg::recip_est(stage_ff[4].num, stodc_pkg::RECIP_24);

      qr_hour               = stodc_pkg::fix24(stage_ff[5].num, stage_ff[5].est);
      stage_in[6]           = stage_ff[5];
      stage_in[6].day_part  = qr_hour.quot[15:0];
      stage_in[6].hour_part = qr_hour.rem[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < stodc_pkg::SPLIT_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < stodc_pkg::SPLIT_STAGES; i++) begin
         if (adv[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   a_parts_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_item.sec_part < 6'd60) && (out_item.min_part < 6'd60)
                    && (out_item.hour_part < 5'd24))
      else $error("split parts out of range");

   a_day_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_item.day_part <= 16'd49710)
      else $error("day part exceeds 32-bit amount");

   a_empty_tail_takes_input: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> !in_stall)
      else $error("input stalled with empty last stage");

endmodule

// ===== sv/scaled_time_of_day_counter_core.sv =====
// time-of-day counter with frame prescaler, top level
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | cmd, paused, rtc_seconds, add_amount
//   rsp     | out       | rsp_valid/rsp_stall  | day_count, hour_now, minute_now,
//           |           |                      | second_now, is_running
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// one transaction per cycle sustained unless the response stalls; a result passes through
// the seven splitter stages (three multiply and correct steps) and then the state register
// the clock state is updated when a transaction enters the response register
// reset is synchronous; counter and registers come up as after a reset command, scale 1
// a stalled response backs up the pipeline, empty stages still take new requests
module scaled_time_of_day_counter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic        req_paused,
   input  logic [5:0]  req_rtc_seconds,
   input  logic [31:0] req_add_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_day_count,
   output logic [4:0]  rsp_hour_now,
   output logic [5:0]  rsp_minute_now,
   output logic [5:0]  rsp_second_now,
   output logic        rsp_is_running,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   stodc_pkg::req_type   req_item;
   stodc_pkg::split_type item;
   logic                 split_valid;
   logic                 split_stall;
   logic                 update;

   logic        rsp_valid_ff;
   logic        running_ff, running_in;
   logic [5:0]  frame_ff, frame_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [15:0] day_ff, day_in;
   logic [5:0]  sync_ff, sync_in;

   logic [5:0]  scale_ff;
   logic [15:0] start_day_ff;
   logic [4:0]  start_hour_ff;
   logic [5:0]  start_minute_ff;

   logic [5:0]  scale;
   logic [6:0]  acc;
   logic [6:0]  acc_wrap;
   logic [6:0]  sec_inc;
   logic [6:0]  sec_wrap;
   logic [6:0]  min_inc;
   logic [6:0]  min_wrap;
   logic [5:0]  hour_inc;
   logic [5:0]  hour_wrap;
   logic [6:0]  rtc_plus;
   logic [6:0]  diff;
   logic        diff_neg;
   logic [11:0] prod;
   logic        too_fast;

   logic [6:0]  sec_sum;
   logic [5:0]  sec_norm;
   logic [1:0]  carry_sec;
   logic [6:0]  min_sum;
   logic [5:0]  min_norm;
   logic [1:0]  carry_min;
   logic [5:0]  hour_sum;
   logic [4:0]  hour_norm;
   logic [1:0]  carry_hour;
   logic [15:0] day_sum;

   assign req_item.cmd         = req_cmd;
   assign req_item.paused      = req_paused;
   assign req_item.rtc_seconds = req_rtc_seconds;
   assign req_item.add_amount  = req_add_amount;

   stodc_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_req    (req_item),
      .out_valid (split_valid),
      .out_stall (split_stall),
      .out_item  (item)
   );

   assign split_stall = rsp_valid_ff && rsp_stall;
   assign update      = split_valid && !split_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_day_count  = day_ff;
   assign rsp_hour_now   = hour_ff;
   assign rsp_minute_now = min_ff;
   assign rsp_second_now = sec_ff;
   assign rsp_is_running = running_ff;
   assign csr_ready      = 1'b1;

   // tick arithmetic
   always_comb begin
      scale     = (scale_ff > stodc_pkg::SCALE_MAX) ? stodc_pkg::SCALE_MAX : scale_ff;
      acc       = {1'b0, frame_ff} + {1'b0, scale};
      acc_wrap  = acc - 7'd60;
      sec_inc   = {1'b0, sec_ff} + 7'd1;
      sec_wrap  = sec_inc - 7'd60;
      min_inc   = {1'b0, min_ff} + 7'd1;
      min_wrap  = min_inc - 7'd60;
      hour_inc  = {1'b0, hour_ff} + 6'd1;
      hour_wrap = hour_inc - 6'd24;
      rtc_plus  = {1'b0, item.rtc_seconds} + 7'd60;
      // elapsed real seconds since last sync, a wrap that still goes negative never holds
      if (item.rtc_seconds >= sync_ff) begin
         diff     = {1'b0, item.rtc_seconds} - {1'b0, sync_ff};
         diff_neg = 1'b0;
      end else begin
         diff     = rtc_plus - {1'b0, sync_ff};
         diff_neg = rtc_plus < {1'b0, sync_ff};
      end
      prod     = {6'd0, diff[5:0]} * {6'd0, scale};
      too_fast = !diff_neg && (prod < 12'd60);
   end

   // add arithmetic, parts already split by the pipeline
   always_comb begin
      sec_sum = {1'b0, sec_ff} + {1'b0, item.sec_part};
      if (sec_sum >= 7'd120) begin
         sec_norm  = 6'(sec_sum - 7'd120);
         carry_sec = 2'd2;
      end else if (sec_sum >= 7'd60) begin
         sec_norm  = 6'(sec_sum - 7'd60);
         carry_sec = 2'd1;
      end else begin
         sec_norm  = sec_sum[5:0];
         carry_sec = 2'd0;
      end
      min_sum = {1'b0, min_ff} + {1'b0, item.min_part} + {5'd0, carry_sec};
      if (min_sum >= 7'd120) begin
         min_norm  = 6'(min_sum - 7'd120);
         carry_min = 2'd2;
      end else if (min_sum >= 7'd60) begin
         min_norm  = 6'(min_sum - 7'd60);
         carry_min = 2'd1;
      end else begin
         min_norm  = min_sum[5:0];
         carry_min = 2'd0;
      end
      hour_sum = {1'b0, hour_ff} + {1'b0, item.hour_part} + {4'd0, carry_min};
      if (hour_sum >= 6'd48) begin
         hour_norm  = 5'(hour_sum - 6'd48);
         carry_hour = 2'd2;
      end else if (hour_sum >= 6'd24) begin
         hour_norm  = 5'(hour_sum - 6'd24);
         carry_hour = 2'd1;
      end else begin
         hour_norm  = hour_sum[4:0];
         carry_hour = 2'd0;
      end
      day_sum = day_ff + item.day_part + {14'd0, carry_hour};
   end

   always_comb begin
      running_in = running_ff;
      frame_in   = frame_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      day_in     = day_ff;
      sync_in    = sync_ff;
      unique case (item.cmd)
         stodc_pkg::CMD_RESET: begin
            running_in = 1'b0;
            day_in     = start_day_ff;
            hour_in    = start_hour_ff;
            min_in     = start_minute_ff;
            sec_in     = '0;
            frame_in   = '0;
         end
         stodc_pkg::CMD_START: begin
            running_in = 1'b1;
            sync_in    = item.rtc_seconds;
         end
         stodc_pkg::CMD_STOP: begin
            running_in = 1'b0;
         end
         stodc_pkg::CMD_TICK: begin
            if (running_ff && !item.paused) begin
               if (acc < 7'd60) begin
                  frame_in = acc[5:0];
               end else begin
                  frame_in = acc_wrap[5:0];
                  if (sec_inc < 7'd60) begin
                     sec_in = sec_inc[5:0];
                  end else if (too_fast) begin
                     sec_in = stodc_pkg::SEC_HOLD;
                  end else begin
                     sync_in = item.rtc_seconds;
                     sec_in  = sec_wrap[5:0];
                     // minute rollover ripples to hour and day
                     if (min_inc < 7'd60) begin
                        min_in = min_inc[5:0];
                     end else begin
                        min_in = min_wrap[5:0];
                        if (hour_inc < 6'd24) begin
                           hour_in = hour_inc[4:0];
                        end else begin
                           hour_in = hour_wrap[4:0];
                           day_in  = day_ff + 16'd1;
                        end
                     end
                  end
               end
            end
         end
         stodc_pkg::CMD_ADD: begin
            sec_in  = sec_norm;
            min_in  = min_norm;
            hour_in = hour_norm;
            day_in  = day_sum;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         frame_ff     <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         hour_ff      <= '0;
         day_ff       <= '0;
         sync_ff      <= '0;
      end else begin
         if (!split_stall) begin
            rsp_valid_ff <= split_valid;
         end
         if (update) begin
            running_ff <= running_in;
            frame_ff   <= frame_in;
            sec_ff     <= sec_in;
            min_ff     <= min_in;
            hour_ff    <= hour_in;
            day_ff     <= day_in;
            sync_ff    <= sync_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= 6'd1;
         start_day_ff    <= '0;
         start_hour_ff   <= '0;
         start_minute_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            stodc_pkg::CSR_TIME_SCALE:   scale_ff        <= csr_wdata[5:0];
            stodc_pkg::CSR_START_DAY:    start_day_ff    <= csr_wdata;
            stodc_pkg::CSR_START_HOUR:   start_hour_ff   <= csr_wdata[4:0];
            stodc_pkg::CSR_START_MINUTE: start_minute_ff <= csr_wdata[5:0];
         endcase
      end
   end

   a_frame_below_60: assert property (@(posedge clock) disable iff (reset)
      frame_ff < 6'd60)
      else $error("prescaler reached 60");

   a_sec_below_60: assert property (@(posedge clock) disable iff (reset)
      sec_ff < 6'd60)
      else $error("seconds reached 60");

   a_reset_cmd: assert property (@(posedge clock) disable iff (reset)
      update && (item.cmd == stodc_pkg::CMD_RESET)
      |=> !running_ff && (sec_ff == 6'd0) && (frame_ff == 6'd0) && rsp_valid_ff)
      else $error("reset command did not clear the clock");

   a_start_cmd: assert property (@(posedge clock) disable iff (reset)
      update && (item.cmd == stodc_pkg::CMD_START)
      |=> running_ff && (sync_ff == $past(item.rtc_seconds)))
      else $error("start command did not run and sync");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the scaled time-of-day counter core
`timescale 1ns / 100ps

module tb;

   localparam logic [2:0] CMD_SPARE_LO   = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI   = 3'd7;
   localparam int         SECS_PER_MIN   = 60;
   localparam int         MINS_PER_HOUR  = 60;
   localparam int         HOURS_PER_DAY  = 24;
   localparam int         PHASES         = 8;
   localparam int         ITEMS_PER_PHASE = 210;
   localparam int         IDLE_SETTLE    = 12;
   localparam int         QUIET_LIMIT    = 1500;

   typedef struct packed {
      logic [15:0] day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        running;
   } reading_type;

   typedef struct packed {
      logic        is_csr;
      logic [1:0]  idx;
      logic [15:0] wdata;
      logic [2:0]  cmd;
      logic        paused;
      logic [5:0]  rtc;
      logic [31:0] amount;
      logic        typed;
      reading_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = stodc_pkg::CMD_RESET;
   logic        req_paused = 1'b0;
   logic [5:0]  req_rtc_seconds = 6'd0;
   logic [31:0] req_add_amount = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_day_count;
   logic [4:0]  rsp_hour_now;
   logic [5:0]  rsp_minute_now;
   logic [5:0]  rsp_second_now;
   logic        rsp_is_running;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = stodc_pkg::CSR_TIME_SCALE;
   logic [15:0] csr_wdata = 16'd0;

   scaled_time_of_day_counter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_paused      (req_paused),
      .req_rtc_seconds (req_rtc_seconds),
      .req_add_amount  (req_add_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_day_count   (rsp_day_count),
      .rsp_hour_now    (rsp_hour_now),
      .rsp_minute_now  (rsp_minute_now),
      .rsp_second_now  (rsp_second_now),
      .rsp_is_running  (rsp_is_running),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock model state and its copy of the registers
   int unsigned cfg_scale = 1, cfg_day = 0, cfg_hour = 0, cfg_min = 0;
   int unsigned m_run = 0, m_frac = 0, m_sec = 0, m_min = 0, m_hour = 0, m_day = 0;
   int unsigned m_sync = 0;

   reading_type  due_readings[$];
   plan_row_type plan[$];

   int  mismatches = 0;
   int  n_items = 0, n_checked = 0, n_csr = 0;
   int  n_holds = 0, n_carries = 0, n_day_wraps = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   int  stall_pick;
   bit  calm = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic reading_type step_clock(input logic [2:0] cmd, input logic paused,
                                              input logic [5:0] rtc,
                                              input logic [31:0] amount);
      int unsigned     scale, acc, diff, rtc_u;
      longint unsigned s, m, h, d;
      reading_type     r;
      rtc_u = rtc;
      unique case (cmd)
         stodc_pkg::CMD_RESET: begin
            m_run  = 0;
            m_day  = cfg_day;
            m_hour = cfg_hour;
            m_min  = cfg_min;
            m_sec  = 0;
            m_frac = 0;
         end
         stodc_pkg::CMD_START: begin
            m_run  = 1;
            m_sync = rtc_u;
         end
         stodc_pkg::CMD_STOP: m_run = 0;
         stodc_pkg::CMD_TICK: begin
            if (m_run != 0 && !paused) begin
               scale = (cfg_scale > stodc_pkg::SCALE_MAX) ? stodc_pkg::SCALE_MAX : cfg_scale;
               acc = m_frac + scale;
               if (acc < SECS_PER_MIN) begin
                  m_frac = acc;
               end else begin
                  m_frac = (acc - SECS_PER_MIN) & 63;
                  m_sec = m_sec + 1;
                  if (m_sec >= SECS_PER_MIN) begin
                     // elapsed rtc seconds wrap through zero; 32-bit wrap is intended
                     diff = (rtc_u >= m_sync) ? rtc_u - m_sync : rtc_u + 60 - m_sync;
                     if (diff * scale < SECS_PER_MIN) begin
                        m_sec = stodc_pkg::SEC_HOLD;
                        n_holds++;
                     end else begin
                        m_sync = rtc_u;
                        m_sec = (m_sec - SECS_PER_MIN) & 63;
                        n_carries++;
                        m_min = m_min + 1;
                        if (m_min >= MINS_PER_HOUR) begin
                           m_min = (m_min - MINS_PER_HOUR) & 63;
                           m_hour = m_hour + 1;
                           if (m_hour >= HOURS_PER_DAY) begin
                              m_hour = (m_hour - HOURS_PER_DAY) & 31;
                              m_day = (m_day + 1) & 16'hFFFF;
                              if (m_day == 0) n_day_wraps++;
                           end
                        end
                     end
                  end
               end
            end
         end
         stodc_pkg::CMD_ADD: begin
            s = longint'(m_sec) + longint'(amount);
            m = longint'(m_min) + s / SECS_PER_MIN;
            h = longint'(m_hour) + m / MINS_PER_HOUR;
            d = longint'(m_day) + h / HOURS_PER_DAY;
            m_sec  = 32'(s % SECS_PER_MIN);
            m_min  = 32'(m % MINS_PER_HOUR);
            m_hour = 32'(h % HOURS_PER_DAY);
            m_day  = 32'(d & 16'hFFFF);
         end
         default: ;
      endcase
      r.day     = m_day[15:0];
      r.hour    = m_hour[4:0];
      r.minute  = m_min[5:0];
      r.second  = m_sec[5:0];
      r.running = m_run[0];
      return r;
   endfunction

   function automatic void plan_csr(input logic [1:0] idx, input logic [15:0] val);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.wdata  = val;
      plan.push_back(row);
   endfunction

   function automatic void plan_item(input logic [2:0] cmd, input logic paused,
                                     input logic [5:0] rtc, input logic [31:0] amount);
      plan_row_type row;
      row = '0;
      row.cmd    = cmd;
      row.paused = paused;
      row.rtc    = rtc;
      row.amount = amount;
      plan.push_back(row);
   endfunction

   function automatic void plan_known(input logic [2:0] cmd, input logic paused,
                                      input logic [5:0] rtc, input logic [31:0] amount,
                                      input logic [15:0] day, input logic [4:0] hour,
                                      input logic [5:0] minute, input logic [5:0] second,
                                      input logic running);
      plan_row_type row;
      row = '0;
      row.cmd    = cmd;
      row.paused = paused;
      row.rtc    = rtc;
      row.amount = amount;
      row.typed  = 1'b1;
      row.want   = '{day, hour, minute, second, running};
      plan.push_back(row);
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      wait_idle();
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         stodc_pkg::CSR_TIME_SCALE:   cfg_scale = val & 63;
         stodc_pkg::CSR_START_DAY:    cfg_day   = val;
         stodc_pkg::CSR_START_HOUR:   cfg_hour  = val & 31;
         stodc_pkg::CSR_START_MINUTE: cfg_min   = val & 63;
         default: ;
      endcase
      n_csr++;
   endtask

   task automatic send_item(input logic [2:0] cmd, input logic paused, input logic [5:0] rtc,
                            input logic [31:0] amount, input logic typed,
                            input reading_type want);
      reading_type got;
      int          pick;
      int          gap;
      req_cmd         <= cmd;
      req_paused      <= paused;
      req_rtc_seconds <= rtc;
      req_add_amount  <= amount;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      got = step_clock(cmd, paused, rtc, amount);
      due_readings.push_back(typed ? want : got);
      n_items++;
      pick = $urandom_range(0, 99);
      if (calm || pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      reading_type want_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_readings.size() == 0) begin
            $display("%0t: result arrived with no transaction pending, actual day %0d",
                     $time, rsp_day_count);
            mismatches++;
         end else begin
            want_r = due_readings.pop_front();
            check_field("day_count", want_r.day, rsp_day_count);
            check_field("hour_now", want_r.hour, rsp_hour_now);
            check_field("minute_now", want_r.minute, rsp_minute_now);
            check_field("second_now", want_r.second, rsp_second_now);
            check_field("is_running", want_r.running, rsp_is_running);
            n_checked++;
         end
      end
   end

   // response backpressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (calm || stall_pick < 55) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end else if (stall_pick < 93) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 40);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL scaled_time_of_day_counter_core");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0]  cmd;
      logic        paused;
      logic [5:0]  rtc;
      logic [31:0] amount;
      logic [15:0] sc, dy, hr, mn;
      int          pick, sel;

      // largest start values, full scale
      plan_csr(stodc_pkg::CSR_TIME_SCALE, 16'd60);
      plan_csr(stodc_pkg::CSR_START_DAY, 16'hFFFF);
      plan_csr(stodc_pkg::CSR_START_HOUR, 16'd23);
      plan_csr(stodc_pkg::CSR_START_MINUTE, 16'd59);
      plan_known(stodc_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b0);
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b0);
      plan_known(stodc_pkg::CMD_START, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b1);
      plan_known(stodc_pkg::CMD_TICK, 1'b1, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b1);
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd1, 1'b1);
      plan_known(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'd58, 16'hFFFF, 5'd23, 6'd59, 6'd59, 1'b1);
      // no rtc time elapsed, so the second holds
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd59, 1'b1);
      // carry all the way up and wrap the day
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd1, 32'd0, 16'd0, 5'd0, 6'd0, 6'd0, 1'b1);
      plan_known(stodc_pkg::CMD_STOP, 1'b0, 6'd0, 32'd0, 16'd0, 5'd0, 6'd0, 6'd0, 1'b0);
      plan_known(CMD_SPARE_LO, 1'b1, 6'd59, 32'hFFFFFFFF, 16'd0, 5'd0, 6'd0, 6'd0, 1'b0);
      plan_known(CMD_SPARE_LO + 3'd1, 1'b0, 6'd0, 32'd0, 16'd0, 5'd0, 6'd0, 6'd0, 1'b0);
      plan_known(CMD_SPARE_HI, 1'b0, 6'd63, 32'd1, 16'd0, 5'd0, 6'd0, 6'd0, 1'b0);
      plan_item(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'hFFFFFFFF);
      plan_item(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'd0);
      plan_known(stodc_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b0);
      plan_known(stodc_pkg::CMD_START, 1'b0, 6'd63, 32'd0, 16'hFFFF, 5'd23, 6'd59, 6'd0, 1'b1);
      plan_known(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'd59, 16'hFFFF, 5'd23, 6'd59, 6'd59, 1'b1);
      // rtc behind the sync point wraps the elapsed count
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd0, 32'd0, 16'd0, 5'd0, 6'd0, 6'd0, 1'b1);
      // zero scale with start values past their ranges
      plan_csr(stodc_pkg::CSR_TIME_SCALE, 16'd0);
      plan_csr(stodc_pkg::CSR_START_DAY, 16'd0);
      plan_csr(stodc_pkg::CSR_START_HOUR, 16'd31);
      plan_csr(stodc_pkg::CSR_START_MINUTE, 16'd63);
      plan_known(stodc_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 16'd0, 5'd31, 6'd63, 6'd0, 1'b0);
      plan_known(stodc_pkg::CMD_START, 1'b0, 6'd60, 32'd0, 16'd0, 5'd31, 6'd63, 6'd0, 1'b1);
      plan_known(stodc_pkg::CMD_TICK, 1'b0, 6'd5, 32'd0, 16'd0, 5'd31, 6'd63, 6'd0, 1'b1);
      plan_item(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'd1);
      // scale above sixty
      plan_csr(stodc_pkg::CSR_TIME_SCALE, 16'd63);
      plan_known(stodc_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 16'd0, 5'd31, 6'd63, 6'd0, 1'b0);
      plan_known(stodc_pkg::CMD_START, 1'b0, 6'd0, 32'd0, 16'd0, 5'd31, 6'd63, 6'd0, 1'b1);
      // an add normalizes the out-of-range minute and hour
      plan_known(stodc_pkg::CMD_ADD, 1'b0, 6'd0, 32'd59, 16'd1, 5'd8, 6'd3, 6'd59, 1'b1);
      plan_item(stodc_pkg::CMD_TICK, 1'b0, 6'd59, 32'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr)
            write_csr(plan[i].idx, plan[i].wdata);
         else
            send_item(plan[i].cmd, plan[i].paused, plan[i].rtc, plan[i].amount,
                      plan[i].typed, plan[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            sc = 16'd60; dy = 16'hFFFF; hr = 16'd23; mn = 16'd59;
         end else if (phase == 1) begin
            sc = 16'd1; dy = 16'd0; hr = 16'd0; mn = 16'd0;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               sc = 16'($urandom_range(0, 4));
               if (sc != 0) sc = sc + 16'd59;
            end else begin
               sc = 16'($urandom_range(1, 60));
            end
            dy = ($urandom_range(0, 4) == 0) ? 16'hFFFF - 16'($urandom_range(0, 2))
                                             : 16'($urandom);
            hr = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(24, 31))
                                             : 16'($urandom_range(0, 23));
            mn = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(60, 63))
                                             : 16'($urandom_range(0, 59));
         end
         write_csr(stodc_pkg::CSR_TIME_SCALE, sc);
         write_csr(stodc_pkg::CSR_START_DAY, dy);
         write_csr(stodc_pkg::CSR_START_HOUR, hr);
         write_csr(stodc_pkg::CSR_START_MINUTE, mn);
         calm = ($urandom_range(0, 3) == 0);
         send_item(stodc_pkg::CMD_RESET, 1'b0, 6'd0, 32'd0, 1'b0, '0);
         send_item(stodc_pkg::CMD_START, 1'b0, 6'($urandom_range(0, 59)), 32'd0, 1'b0, '0);

         repeat (ITEMS_PER_PHASE) begin
            pick   = $urandom_range(0, 99);
            paused = 1'b0;
            rtc    = 6'($urandom_range(0, 59));
            amount = $urandom;
            if (m_run == 0 && pick < 40) begin
               cmd = stodc_pkg::CMD_START;
            end else if (pick < 60) begin
               cmd = stodc_pkg::CMD_TICK;
               paused = ($urandom_range(0, 9) == 0);
               sel = $urandom_range(0, 19);
               // rtc close to the sync point makes the hold likely
               if (sel < 6) rtc = 6'((m_sync + $urandom_range(0, 2)) % SECS_PER_MIN);
               else if (sel == 19) rtc = 6'($urandom_range(60, 63));
            end else if (pick < 70) begin
               cmd = stodc_pkg::CMD_ADD;
               amount = stodc_pkg::SEC_HOLD - m_sec;
            end else if (pick < 76) begin
               cmd = stodc_pkg::CMD_ADD;
               amount = $urandom_range(0, 400);
            end else if (pick < 81) begin
               cmd = stodc_pkg::CMD_ADD;
               if ($urandom_range(0, 3) == 0) amount = 32'hFFFFFFFF - $urandom_range(0, 3);
            end else if (pick < 86) begin
               cmd = stodc_pkg::CMD_START;
               if ($urandom_range(0, 9) == 0) rtc = 6'($urandom_range(60, 63));
            end else if (pick < 90) begin
               cmd = stodc_pkg::CMD_STOP;
            end else if (pick < 94) begin
               cmd = stodc_pkg::CMD_RESET;
            end else begin
               cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
               paused = 1'($urandom_range(0, 1));
            end
            send_item(cmd, paused, rtc, amount, 1'b0, '0);
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("ran %0d transactions and %0d register writes, %0d results checked",
               n_items, n_csr, n_checked);
      $display("saw %0d second holds, %0d minute carries, %0d day wraps on carry",
               n_holds, n_carries, n_day_wraps);
      if (mismatches == 0)
         $display("PASS scaled_time_of_day_counter_core");
      else
         $display("FAIL scaled_time_of_day_counter_core");
      $finish;
   end

endmodule
